// ----- rtl/core/vhrc_pkg.sv -----
package vhrc_pkg;

    localparam int DEF_ENTRIES      = 1024;
    localparam int DEF_VALUE_DOMAIN = 1024;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_CHANGE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // status from the tree engine back to the front end
    typedef struct packed {
        logic clearing;
        logic pop;
    } vhrc_back_stat_t;

endpackage

// ----- rtl/core/value_histogram_range_count.sv -----
// channel  | handshake          | payload
// request  | req_valid/req_stall | req_type entry_index new_value range_low range_high
// result   | match_valid/match_stall | match_count
//
// one request at a time in the tree engine; a two-deep queue sits in front of it
// change of a loaded entry: two leaf-to-root walks
// first load: a single leaf-to-root walk
// after reset a clearing pass over the node and entry stores holds req_stall high
// a result held by match_stall parks the engine at the end of the next query; the queue
// then fills and raises req_stall
module value_histogram_range_count
    import vhrc_pkg::*;
#(
    parameter int ENTRIES      = DEF_ENTRIES,
    parameter int VALUE_DOMAIN = DEF_VALUE_DOMAIN,
    localparam int EW = $clog2(ENTRIES),
    localparam int VW = $clog2(VALUE_DOMAIN),
    localparam int LW = VW + 2,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  logic [1:0]    req_type,
    input  logic [EW-1:0] entry_index,
    input  logic [VW-1:0] new_value,
    input  logic [VW-1:0] range_low,
    input  logic [VW-1:0] range_high,
    output logic          match_valid,
    input  logic          match_stall,
    output logic [CW-1:0] match_count
);

    vhrc_back_stat_t stat;
    logic            cmd_valid, cmd_query;
    logic [EW-1:0]   cmd_idx;
    logic [VW-1:0]   cmd_val;
    logic [LW-1:0]   cmd_l, cmd_r;

    vhrc_front #(.ENTRIES(ENTRIES), .VALUE_DOMAIN(VALUE_DOMAIN)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .new_value   (new_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .stat        (stat),
        .cmd_valid   (cmd_valid),
        .cmd_query   (cmd_query),
        .cmd_idx     (cmd_idx),
        .cmd_val     (cmd_val),
        .cmd_l       (cmd_l),
        .cmd_r       (cmd_r)
    );

    vhrc_back #(.ENTRIES(ENTRIES), .VALUE_DOMAIN(VALUE_DOMAIN)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_query   (cmd_query),
        .cmd_idx     (cmd_idx),
        .cmd_val     (cmd_val),
        .cmd_l       (cmd_l),
        .cmd_r       (cmd_r),
        .stat        (stat),
        .match_valid (match_valid),
        .match_stall (match_stall),
        .match_count (match_count)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        match_valid |-> (match_count <= CW'(ENTRIES)))
        else $error("match_count above entry count");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> cmd_valid)
        else $error("queue popped while empty");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> req_stall)
        else $error("request taken during clearing pass");

    a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !stat.pop && !match_valid)
        else $error("engine active during clearing pass");

endmodule

// ----- rtl/core/vhrc_ram.sv -----
module vhrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/vhrc_front.sv -----
module vhrc_front
    import vhrc_pkg::*;
#(
    parameter int ENTRIES      = DEF_ENTRIES,
    parameter int VALUE_DOMAIN = DEF_VALUE_DOMAIN,
    localparam int EW = $clog2(ENTRIES),
    localparam int VW = $clog2(VALUE_DOMAIN),
    localparam int NW = VW + 1,
    localparam int LW = NW + 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  logic [1:0]      req_type,
    input  logic [EW-1:0]   entry_index,
    input  logic [VW-1:0]   new_value,
    input  logic [VW-1:0]   range_low,
    input  logic [VW-1:0]   range_high,
    input  vhrc_back_stat_t stat,
    output logic            cmd_valid,
    output logic            cmd_query,
    output logic [EW-1:0]   cmd_idx,
    output logic [VW-1:0]   cmd_val,
    output logic [LW-1:0]   cmd_l,
    output logic [LW-1:0]   cmd_r
);

    logic            q_query_reg [2];
    logic [EW-1:0]   q_idx_reg [2];
    logic [VW-1:0]   q_val_reg [2];
    logic [LW-1:0]   q_l_reg [2];
    logic [LW-1:0]   q_r_reg [2];
    logic            rd_ptr_reg, rd_ptr_next;
    logic            wr_ptr_reg, wr_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;

    logic            is_upd, is_query, keep, push, nonempty;
    logic [VW-1:0]   hi_clamp;
    logic [LW-1:0]   l_calc, r_calc;

    always_comb
    begin
        is_upd   = (req_type == REQ_LOAD) || (req_type == REQ_CHANGE);
        is_query = (req_type == REQ_QUERY);
        keep     = is_query ||
                   (is_upd && ({1'b0, entry_index} < (EW+1)'(ENTRIES)) &&
                    ({1'b0, new_value} < (VW+1)'(VALUE_DOMAIN)));
        nonempty = (range_low <= range_high) &&
                   ({1'b0, range_low} < (VW+1)'(VALUE_DOMAIN));
        hi_clamp = ({1'b0, range_high} >= (VW+1)'(VALUE_DOMAIN)) ?
                   VW'(VALUE_DOMAIN - 1) : range_high;
        // empty range collapses to l == r so the walk ends at once
        l_calc   = nonempty ? (LW'(range_low) + LW'(VALUE_DOMAIN)) : '0;
        r_calc   = nonempty ? (LW'(hi_clamp) + LW'(VALUE_DOMAIN) + LW'(1)) : '0;
        req_stall = (cnt_reg == 2'd2) || stat.clearing;
        push      = req_valid && !req_stall && keep;
        rd_ptr_next = stat.pop ? ~rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        cnt_next    = cnt_reg + (push ? 2'd1 : 2'd0) - (stat.pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_query_reg[wr_ptr_reg] <= is_query;
            q_idx_reg[wr_ptr_reg]   <= entry_index;
            q_val_reg[wr_ptr_reg]   <= new_value;
            q_l_reg[wr_ptr_reg]     <= l_calc;
            q_r_reg[wr_ptr_reg]     <= r_calc;
        end
    end

    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_query = q_query_reg[rd_ptr_reg];
    assign cmd_idx   = q_idx_reg[rd_ptr_reg];
    assign cmd_val   = q_val_reg[rd_ptr_reg];
    assign cmd_l     = q_l_reg[rd_ptr_reg];
    assign cmd_r     = q_r_reg[rd_ptr_reg];

endmodule

// ----- rtl/core/vhrc_back.sv -----
module vhrc_back
    import vhrc_pkg::*;
#(
    parameter int ENTRIES      = DEF_ENTRIES,
    parameter int VALUE_DOMAIN = DEF_VALUE_DOMAIN,
    localparam int EW = $clog2(ENTRIES),
    localparam int VW = $clog2(VALUE_DOMAIN),
    localparam int NW = VW + 1,
    localparam int LW = NW + 1,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_query,
    input  logic [EW-1:0]   cmd_idx,
    input  logic [VW-1:0]   cmd_val,
    input  logic [LW-1:0]   cmd_l,
    input  logic [LW-1:0]   cmd_r,
    output vhrc_back_stat_t stat,
    output logic            match_valid,
    input  logic            match_stall,
    output logic [CW-1:0]   match_count
);

    localparam int CLR_LEN = (2 * VALUE_DOMAIN > ENTRIES) ? 2 * VALUE_DOMAIN : ENTRIES;
    localparam int CLRW    = $clog2(CLR_LEN);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_U_ENT = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_Q_L   = 3'd4;
    localparam logic [2:0] S_Q_R   = 3'd5;
    localparam logic [2:0] S_Q_OUT = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [CLRW-1:0] clr_reg, clr_next;
    logic [NW-1:0]   node_reg, node_next;
    logic            dec_reg, dec_next;
    logic [EW-1:0]   idx_reg, idx_next;
    logic [VW-1:0]   val_reg, val_next;
    logic [LW-1:0]   l_reg, l_next, r_reg, r_next, r_dec;
    logic [CW-1:0]   acc_reg, acc_next;
    logic            pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   out_count_reg, out_count_next;

    logic            node_we;
    logic [NW-1:0]   node_waddr, node_raddr, node_up;
    logic [CW-1:0]   node_wdata, node_rdata;
    logic            ent_we;
    logic [EW-1:0]   ent_waddr, ent_raddr;
    logic [VW:0]     ent_wdata, ent_rdata;

    vhrc_ram #(.WIDTH(CW), .DEPTH(2 * VALUE_DOMAIN)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // entry store holds {loaded, value}
    vhrc_ram #(.WIDTH(VW + 1), .DEPTH(ENTRIES)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        dec_next       = dec_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && match_stall;
        out_count_next = out_count_reg;
        node_we        = 1'b0;
        node_waddr     = node_reg;
        node_wdata     = '0;
        node_raddr     = node_reg;
        ent_we         = 1'b0;
        ent_waddr      = idx_reg;
        ent_wdata      = {1'b1, val_reg};
        ent_raddr      = cmd_idx;
        stat.clearing  = 1'b0;
        stat.pop       = 1'b0;
        node_up        = node_reg >> 1;
        r_dec          = r_reg - LW'(1);

        case (state_reg)
            S_CLEAR:
            begin
                stat.clearing = 1'b1;
                node_we    = ({1'b0, clr_reg} < (CLRW+1)'(2 * VALUE_DOMAIN));
                node_waddr = clr_reg[NW-1:0];
                node_wdata = '0;
                ent_we     = ({1'b0, clr_reg} < (CLRW+1)'(ENTRIES));
                ent_waddr  = clr_reg[EW-1:0];
                ent_wdata  = '0;
                clr_next   = clr_reg + CLRW'(1);
                if (clr_reg == CLRW'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    stat.pop = 1'b1;
                    idx_next = cmd_idx;
                    val_next = cmd_val;
                    l_next   = cmd_l;
                    r_next   = cmd_r;
                    acc_next = '0;
                    pend_next = 1'b0;
                    state_next = cmd_query ? S_Q_L : S_U_ENT;
                end
            end
            S_U_ENT:
            begin
                ent_we = 1'b1;
                if (ent_rdata[VW])
                begin
                    node_next  = NW'(VALUE_DOMAIN) + NW'(ent_rdata[VW-1:0]);
                    dec_next   = 1'b1;
                end
                else
                begin
                    node_next  = NW'(VALUE_DOMAIN) + NW'(val_reg);
                    dec_next   = 1'b0;
                end
                node_raddr = node_next;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // write back the node read last cycle, fetch its parent or the new leaf
                node_we = 1'b1;
                if (dec_reg)
                begin
                    node_wdata = (node_rdata == '0) ? '0 : node_rdata - CW'(1);
                end
                else
                begin
                    node_wdata = node_rdata + CW'(1);
                end
                if (node_up != '0)
                begin
                    node_next = node_up;
                end
                else if (dec_reg)
                begin
                    dec_next  = 1'b0;
                    node_next = NW'(VALUE_DOMAIN) + NW'(val_reg);
                end
                else
                begin
                    state_next = S_IDLE;
                end
                node_raddr = node_next;
            end
            S_Q_L:
            begin
                acc_next  = acc_reg + (pend_reg ? node_rdata : '0);
                pend_next = 1'b0;
                if (l_reg < r_reg)
                begin
                    if (l_reg[0])
                    begin
                        node_raddr = l_reg[NW-1:0];
                        pend_next  = 1'b1;
                        l_next     = l_reg + LW'(1);
                    end
                    state_next = S_Q_R;
                end
                else
                begin
                    state_next = S_Q_OUT;
                end
            end
            S_Q_R:
            begin
                acc_next  = acc_reg + (pend_reg ? node_rdata : '0);
                pend_next = 1'b0;
                if (r_reg[0])
                begin
                    node_raddr = r_dec[NW-1:0];
                    pend_next  = 1'b1;
                    r_next     = r_dec >> 1;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                l_next     = l_reg >> 1;
                state_next = S_Q_L;
            end
            S_Q_OUT:
            begin
                if (!out_valid_reg || !match_stall)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            dec_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dec_reg       <= dec_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        idx_reg       <= idx_next;
        val_reg       <= val_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        acc_reg       <= acc_next;
        out_count_reg <= out_count_next;
    end

    assign match_valid = out_valid_reg;
    assign match_count = out_count_reg;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import vhrc_pkg::*;

    localparam int NUM_ENTRIES   = DEF_ENTRIES;
    localparam int NUM_VALUES    = DEF_VALUE_DOMAIN;
    localparam int RANDOM_ITEMS  = 1130;
    localparam int IDLE_LIMIT    = 8000;
    localparam int HOLD_CYCLES   = 500;
    localparam int TAIL_CYCLES   = 80;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] kind;
        logic [9:0] idx;
        logic [9:0] val;
        logic [9:0] lo;
        logic [9:0] hi;
        bit         typed;
        logic [10:0] count;
    } hist_req_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [9:0]  entry_index;
    logic [9:0]  new_value;
    logic [9:0]  range_low;
    logic [9:0]  range_high;
    logic        match_valid;
    logic        match_stall;
    logic [10:0] match_count;

    // shadow of the block: value held by each entry and population per value
    logic [9:0]  shadow_value [NUM_ENTRIES];
    bit          shadow_loaded [NUM_ENTRIES];
    int          value_population [NUM_VALUES];
    int          loaded_list [$];

    logic [10:0] pending_counts [$];
    hist_req_t   directed [$];
    int          fail_count;
    int          accepted_reqs;
    bit          hold_done;

    value_histogram_range_count uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .new_value   (new_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .match_valid (match_valid),
        .match_stall (match_stall),
        .match_count (match_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [10:0] count_in_range(logic [9:0] lo, logic [9:0] hi);
        int total;
        total = 0;
        if (lo <= hi)
        begin
            for (int v = lo; v <= hi; v++)
                total += value_population[v];
        end
        return total[10:0];
    endfunction

    // update the shadow for one accepted transfer and queue any expected count
    function automatic void apply_request(hist_req_t r);
        logic [10:0] cnt;
        if (r.kind == REQ_LOAD || r.kind == REQ_CHANGE)
        begin
            if (shadow_loaded[r.idx])
                value_population[shadow_value[r.idx]]--;
            else
                loaded_list = {loaded_list, int'(r.idx)};
            shadow_value[r.idx] = r.val;
            shadow_loaded[r.idx] = 1'b1;
            value_population[r.val]++;
        end
        else if (r.kind == REQ_QUERY)
        begin
            cnt = count_in_range(r.lo, r.hi);
            pending_counts = {pending_counts, (r.typed ? r.count : cnt)};
        end
    endfunction

    function automatic hist_req_t mk(logic [1:0] k, int i, int v, int lo, int hi,
                                     bit typed = 0, int c = 0);
        hist_req_t r;
        r.kind = k;
        r.idx = 10'(i);
        r.val = 10'(v);
        r.lo = 10'(lo);
        r.hi = 10'(hi);
        r.typed = typed;
        r.count = 11'(c);
        return r;
    endfunction

    function automatic hist_req_t random_request();
        hist_req_t r;
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        r = mk(2'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 1023));
        if (pick < 40)
            r.kind = REQ_LOAD;
        else if (pick < 65)
        begin
            // only entries that already hold a value are changed
            if (loaded_list.size() == 0)
                r.kind = REQ_LOAD;
            else
            begin
                r.kind = REQ_CHANGE;
                r.idx = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
            end
        end
        else if (pick < 95)
        begin
            r.kind = REQ_QUERY;
            if ($urandom_range(0, 2) == 0)
            begin
                span = $urandom_range(0, 40);
                r.hi = 10'((r.lo + span > 1023) ? 1023 : r.lo + span);
            end
        end
        else
            r.kind = REQ_UNUSED;
        return r;
    endfunction

    task automatic send(hist_req_t r);
        req_valid   <= 1'b1;
        req_type    <= r.kind;
        entry_index <= r.idx;
        new_value   <= r.val;
        range_low   <= r.lo;
        range_high  <= r.hi;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        apply_request(r);
        accepted_reqs++;
    endtask

    task automatic maybe_gap(ref int burst_left);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            req_type  <= 2'($urandom_range(0, 3));
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender
    initial
    begin
        int burst_left;
        hist_req_t r;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_type    = '0;
        entry_index = '0;
        new_value   = '0;
        range_low   = '0;
        range_high  = '0;
        fail_count  = 0;
        accepted_reqs = 0;
        burst_left  = 0;
        for (int v = 0; v < NUM_VALUES; v++)
            value_population[v] = 0;
        for (int e = 0; e < NUM_ENTRIES; e++)
            shadow_loaded[e] = 1'b0;

        directed = {directed, mk(REQ_QUERY, 0, 0, 0, 1023, 1, 0)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 1023, 0, 1, 0)};
        directed = {directed, mk(REQ_LOAD, 0, 0, 0, 0)};
        directed = {directed, mk(REQ_LOAD, 1023, 1023, 1023, 1023)};
        directed = {directed, mk(REQ_LOAD, 5, 512, 0, 0)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 0, 1023, 1, 3)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 0, 0, 1, 1)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 1023, 1023, 1, 1)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 512, 512)};
        directed = {directed, mk(REQ_CHANGE, 5, 0, 0, 0)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 0, 0)};
        directed = {directed, mk(REQ_LOAD, 0, 7, 0, 0)};
        directed = {directed, mk(REQ_UNUSED, 1023, 1023, 0, 1023)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 1, 1022)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 1023, 0, 1, 0)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 512, 511, 1, 0)};
        directed = {directed, mk(REQ_CHANGE, 1023, 511, 0, 0)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 0, 1023)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 511, 512)};
        directed = {directed, mk(REQ_QUERY, 0, 0, 7, 7)};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            send(directed[k]);
            maybe_gap(burst_left);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r = random_request();
            send(r);
            maybe_gap(burst_left);
        end
        req_valid <= 1'b0;

        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // receiver: stall mode repicked at random when the phase counter wraps, plus one long hold-off
    initial
    begin
        int mode;
        int phase;
        logic [10:0] want;
        match_stall = 1'b0;
        hold_done = 1'b0;
        mode = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (match_valid && !match_stall)
            begin
                if (pending_counts.size() == 0)
                begin
                    $error("unexpected transfer: match_count actual %0d", match_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_counts.pop_front();
                    if (match_count !== want)
                    begin
                        $error("match_count mismatch: expected %0d actual %0d",
                               want, match_count);
                        fail_count++;
                    end
                end
            end
            if (!hold_done && accepted_reqs >= 400)
            begin
                hold_done = 1'b1;
                match_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                // the transfer check above resumes next cycle; a result cannot
                // transfer while stall is held high
            end
            if (phase == 0)
                mode = $urandom_range(0, 2);
            phase = (phase + 1) % 64;
            case (mode)
                0: match_stall <= 1'b0;
                1: match_stall <= ($urandom_range(0, 3) == 0);
                default: match_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // watchdog on cycles with no transfer on either channel
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (match_valid && !match_stall))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
rtl/core/vhrc_pkg.sv
rtl/core/vhrc_ram.sv
rtl/core/vhrc_front.sv
rtl/core/vhrc_back.sv
rtl/core/value_histogram_range_count.sv
test/tb.sv
